>>> rtl/core/u16u8_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

    // One input beat: a raw UTF-16 byte and the end-of-stream mark.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_beat;

    // One output beat: a UTF-8 byte and the last-of-its-input mark.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_beat;

    // Bytes that one input beat produces, first byte in the top lane.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
    } t_seq;

    // Number of encoded bytes suppressed at the start of each stream.
    localparam logic [1:0] SKIP_RESET = 2'd3;

    // Lead byte markers and the surrogate classes on the top six unit bits.
    localparam logic [7:0] LEAD_2     = 8'hC0;
    localparam logic [7:0] LEAD_3     = 8'hE0;
    localparam logic [7:0] LEAD_4     = 8'hF0;
    localparam logic [7:0] CONT       = 8'h80;
    localparam logic [5:0] SURR_HIGH  = 6'b110110;
    localparam logic [5:0] SURR_LOW   = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

endpackage
`default_nettype wire

>>> rtl/core/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder.
//
//   channel   | direction | handshake              | beat
//   ----------+-----------+------------------------+-----------------------------
//   input     | in        | push / full            | one UTF-16 byte + stream end
//   result    | out       | pop / empty            | one UTF-8 byte + run last
//   config    | in        | i_cfg_valid/o_cfg_ready | byte order (0 big, 1 little)
//
// One input beat is accepted per cycle while the sequence queue has room; a
// completed unit yields zero to four output bytes, sent one per cycle by the back
// end while the result side pops; this output rate sets the sustained throughput.
// Bytes pass the sequence queue, work register and output register in turn.
// Reset is synchronous and active low and restores big-endian order and the
// suppression of the first three bytes. Both sides stall independently.
`default_nettype none
module utf16_to_utf8_transcoder #(
    parameter int DEPTH = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire u16u8_pkg::t_in_beat i_in,
    output logic                     empty,
    input  wire logic                pop,
    output u16u8_pkg::t_out_beat     o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_data
);

    logic            accept;
    logic            seq_push;
    u16u8_pkg::t_seq seq_in;
    logic            q_valid;
    logic            q_pop;
    u16u8_pkg::t_seq q_seq;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_seq       (seq_in),
        .o_seq_push  (seq_push)
    );

    u16u8_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (seq_push),
        .i_seq   (seq_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_seq   (q_seq)
    );

    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_seq   (q_seq),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

>>> rtl/core/u16u8_front.sv
// Front end: builds code units, encodes them and applies the start-of-stream suppression.
`default_nettype none
module u16u8_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire u16u8_pkg::t_in_beat i_in,
    input  wire logic                i_cfg_write,
    input  wire logic                i_cfg_data,
    output u16u8_pkg::t_seq          o_seq,
    output logic                     o_seq_push
);

    logic        r_byte_order, n_byte_order;
    logic        r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [9:0]  r_hs_bits, n_hs_bits;
    logic        r_hs_valid, n_hs_valid;
    logic [1:0]  r_skip, n_skip;

    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic [20:0] code;
    logic [31:0] enc_data;
    logic [2:0]  enc_n;
    logic        complete;
    logic [2:0]  produced;
    logic [1:0]  drop;

    // Assemble the unit and classify it.
    always_comb begin
        unit     = r_byte_order ? {i_in.in_byte, r_held} : {r_held, i_in.in_byte};
        is_high  = (unit[15:10] == u16u8_pkg::SURR_HIGH);
        is_low   = (unit[15:10] == u16u8_pkg::SURR_LOW);
        code     = u16u8_pkg::SUPP_BASE + 21'({r_hs_bits, unit[9:0]});
        complete = i_accept && r_phase;
    end

    // Encode the unit; bytes are packed from the top lane down.
    always_comb begin
        enc_data = '0;
        enc_n    = 3'd0;
        priority if (is_high) begin
            enc_n = 3'd0;
        end else if (r_hs_valid && is_low) begin
            enc_data = {u16u8_pkg::LEAD_4 | {5'd0, code[20:18]},
                        u16u8_pkg::CONT | {2'd0, code[17:12]},
                        u16u8_pkg::CONT | {2'd0, code[11:6]},
                        u16u8_pkg::CONT | {2'd0, code[5:0]}};
            enc_n    = 3'd4;
        end else if (unit[15:7] == 9'd0) begin
            enc_data = {unit[7:0], 24'd0};
            enc_n    = 3'd1;
        end else if (unit[15:11] == 5'd0) begin
            enc_data = {u16u8_pkg::LEAD_2 | {3'd0, unit[10:6]},
                        u16u8_pkg::CONT | {2'd0, unit[5:0]}, 16'd0};
            enc_n    = 3'd2;
        end else begin
            enc_data = {u16u8_pkg::LEAD_3 | {4'd0, unit[15:12]},
                        u16u8_pkg::CONT | {2'd0, unit[11:6]},
                        u16u8_pkg::CONT | {2'd0, unit[5:0]}, 8'd0};
            enc_n    = 3'd3;
        end
    end

    // Drop as many leading bytes as the suppression counter still asks for.
    always_comb begin
        produced   = complete ? enc_n : 3'd0;
        drop       = (produced < {1'b0, r_skip}) ? produced[1:0] : r_skip;
        o_seq.data = enc_data << {drop, 3'b000};
        o_seq.count = produced - {1'b0, drop};
        o_seq_push = i_accept && (o_seq.count != 3'd0);
    end

    // Next stream state.
    always_comb begin
        n_byte_order = i_cfg_write ? i_cfg_data : r_byte_order;
        n_phase      = r_phase;
        n_held       = r_held;
        n_hs_bits    = r_hs_bits;
        n_hs_valid   = r_hs_valid;
        n_skip       = r_skip - drop;
        if (i_accept) begin
            if (!r_phase) begin
                n_held  = i_in.in_byte;
                n_phase = 1'b1;
            end else begin
                n_held  = 8'd0;
                n_phase = 1'b0;
                if (is_high) begin
                    n_hs_bits  = unit[9:0];
                    n_hs_valid = 1'b1;
                end else begin
                    n_hs_bits  = 10'd0;
                    n_hs_valid = 1'b0;
                end
            end
            if (i_in.stream_end) begin
                n_phase    = 1'b0;
                n_held     = 8'd0;
                n_hs_bits  = 10'd0;
                n_hs_valid = 1'b0;
                n_skip     = u16u8_pkg::SKIP_RESET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
            r_phase      <= 1'b0;
            r_held       <= 8'd0;
            r_hs_bits    <= 10'd0;
            r_hs_valid   <= 1'b0;
            r_skip       <= u16u8_pkg::SKIP_RESET;
        end else begin
            r_byte_order <= n_byte_order;
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_hs_bits    <= n_hs_bits;
            r_hs_valid   <= n_hs_valid;
            r_skip       <= n_skip;
        end
    end

`ifndef SYNTH
    // A sequence that reaches the queue means suppression is finished for this stream.
    a_skip_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seq_push && !i_in.stream_end) |=> (r_skip == 2'd0))
        else $error("bytes queued while suppression still pending");
`endif

endmodule
`default_nettype wire

>>> rtl/core/u16u8_queue.sv
// Short queue of encoded byte sequences between the front and back ends.
`default_nettype none
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire u16u8_pkg::t_seq i_seq,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output u16u8_pkg::t_seq      o_seq
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u16u8_pkg::t_seq r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_seq   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_seq;
        end
    end

`ifndef SYNTH
    // The front end only pushes while the queue has room.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full sequence queue");

    // The fill count stays within the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("sequence queue count out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/core/u16u8_back.sv
// Back end: serializes queued sequences into single output beats through an output register.
`default_nettype none
module u16u8_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire u16u8_pkg::t_seq   i_q_seq,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output u16u8_pkg::t_out_beat   o_out
);

    logic [31:0]          r_data, n_data;
    logic [2:0]           r_left, n_left;
    logic                 r_out_valid, n_out_valid;
    u16u8_pkg::t_out_beat r_out, n_out;

    logic       out_free;
    logic       emit;
    logic [2:0] left_after;

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    // Emit one byte whenever the output register frees up; reload the work register
    // from the queue as soon as its last byte leaves.
    always_comb begin
        out_free    = !r_out_valid || i_pop;
        emit        = out_free && (r_left != 3'd0);
        left_after  = r_left - 3'(emit);
        o_q_pop     = i_q_valid && (left_after == 3'd0);
        n_data      = emit ? (r_data << 8) : r_data;
        n_left      = left_after;
        if (o_q_pop) begin
            n_data = i_q_seq.data;
            n_left = i_q_seq.count;
        end
        n_out       = r_out;
        n_out_valid = i_pop ? 1'b0 : r_out_valid;
        if (emit) begin
            n_out.out_byte = r_data[31:24];
            n_out.run_last = (r_left == 3'd1);
            n_out_valid    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_out  <= n_out;
    end

`ifndef SYNTH
    // Every sequence taken from the queue carries one to four bytes.
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (i_q_seq.count != 3'd0 && i_q_seq.count <= 3'd4))
        else $error("empty or oversized sequence loaded");
`endif

endmodule
`default_nettype wire
